// ----- hw/rtl/fcr_pkg.sv -----
// ============================================================================
// Framed command receiver package
// Shared command codes, frame constants and the command text tables.
// ============================================================================
package fcr_pkg;

    // Poll answer codes.
    typedef enum logic [1:0] {
        CMD_NONE      = 2'd0,
        CMD_STOP_RUN  = 2'd1,
        CMD_START_RUN = 2'd2
    } cmd_t;

    // Frame sync character.
    localparam logic [7:0] CHAR_A = 8'h41;

    // Command lengths in bytes.
    localparam int STOP_LEN  = 7;
    localparam int START_LEN = 8;

    // Command text, one byte per entry.
    localparam logic [7:0] STOP_TEXT [STOP_LEN] = '{
        8'h73, 8'h74, 8'h6f, 8'h70, 8'h72, 8'h75, 8'h6e
    };
    localparam logic [7:0] START_TEXT [START_LEN] = '{
        8'h73, 8'h74, 8'h61, 8'h72, 8'h74, 8'h72, 8'h75, 8'h6e
    };

    // Expected byte at position k of the selected command text.
    function automatic logic [7:0] cmd_char(input logic start_sel, input logic [2:0] k);
        logic [7:0] ch;
        ch = START_TEXT[k];
        if (!start_sel)
        begin
            ch = (k == 3'd7) ? 8'h00 : STOP_TEXT[k];
        end
        return ch;
    endfunction

endpackage

// ----- hw/rtl/fcr_if.sv -----
// ============================================================================
// Framed command receiver channels
// Valid/ready request channel for incoming items and response channel.
// ============================================================================

// Incoming request: a received byte or a poll.
interface fcr_req_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

// Outgoing response: the poll answer.
interface fcr_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;

    modport source (output valid, output command, input ready);
    modport sink   (input valid, input command, output ready);
endinterface

// ----- hw/rtl/framed_command_receiver_core.sv -----
// A received byte is taken in the idle state; the block stays ready for more bytes.
// A poll with no matching candidate goes straight to the done state; a poll that
// compares the stored payload steps one byte at a time through the read and check
// states, the single store read port and comparator, for up to 8 bytes.
// Reset clears all control state; the payload store is not cleared.
// ============================================================================
// Framed command receiver core
// Deframes 'A' 'A' length payload frames and matches the payload against
// the stop and start command strings with one shared byte comparator.
// ============================================================================
module framed_command_receiver_core #(
    parameter int BUF_DEPTH = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    fcr_req_if.sink  req,
    fcr_rsp_if.source rsp
);
    import fcr_pkg::*;

    localparam int AW  = $clog2(BUF_DEPTH);
    localparam int WIW = $clog2(BUF_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_CHECK = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t          state_reg,     state_next;
    logic [1:0]      run_reg,       run_next;
    logic [7:0]      remain_reg,    remain_next;
    logic [WIW-1:0]  wi_reg,        wi_next;
    logic            ovf_reg,       ovf_next;
    logic            frame_reg,     frame_next;
    logic            sel_reg,       sel_next;
    logic [2:0]      idx_reg,       idx_next;
    cmd_t            cmd_reg,       cmd_next;
    logic            out_valid_reg, out_valid_next;
    cmd_t            out_cmd_reg,   out_cmd_next;

    logic [7:0]      store_mem [BUF_DEPTH];
    logic [7:0]      rd_data_reg;
    logic            mem_we;
    logic [AW-1:0]   rd_addr;
    logic            byte_acc;
    logic            poll_acc;
    logic            out_load;
    logic [2:0]      last_idx;

    // Handshake decode.
    assign req.ready = (state_reg == ST_IDLE);
    assign byte_acc  = req.valid && req.ready && !req.mode;
    assign poll_acc  = req.valid && req.ready && req.mode;
    assign rd_addr   = {{(AW-3){1'b0}}, idx_reg};
    assign last_idx  = sel_reg ? 3'(START_LEN - 1) : 3'(STOP_LEN - 1);

    // Response channel driven from the output register.
    assign rsp.valid   = out_valid_reg;
    assign rsp.command = out_cmd_reg;

    // Deframer and compare sequencer.
    always_comb
    begin
        state_next  = state_reg;
        run_next    = run_reg;
        remain_next = remain_reg;
        wi_next     = wi_reg;
        ovf_next    = ovf_reg;
        frame_next  = frame_reg;
        sel_next    = sel_reg;
        idx_next    = idx_reg;
        cmd_next    = cmd_reg;
        mem_we      = 1'b0;
        out_load    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (byte_acc)
                begin
                    // A pending payload byte is stored first.
                    if (remain_reg != 8'd0)
                    begin
                        remain_next = remain_reg - 8'd1;
                        if (wi_reg < WIW'(BUF_DEPTH))
                        begin
                            mem_we  = 1'b1;
                            wi_next = wi_reg + WIW'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        if (remain_reg == 8'd1)
                        begin
                            frame_next = 1'b1;
                        end
                    end
                    // The byte after two 'A's is the length.
                    if (run_reg == 2'd2)
                    begin
                        remain_next = req.rx_byte;
                    end
                    // The first 'A' of a run restarts the frame.
                    if (req.rx_byte == CHAR_A)
                    begin
                        if (run_reg == 2'd0)
                        begin
                            wi_next    = '0;
                            ovf_next   = 1'b0;
                            frame_next = 1'b0;
                        end
                        if (run_reg != 2'd3)
                        begin
                            run_next = run_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        run_next = 2'd0;
                    end
                end
                else if (poll_acc)
                begin
                    cmd_next   = CMD_NONE;
                    state_next = ST_DONE;
                    if (frame_reg)
                    begin
                        frame_next = 1'b0;
                        idx_next   = 3'd0;
                        if (!ovf_reg && wi_reg == WIW'(STOP_LEN))
                        begin
                            sel_next   = 1'b0;
                            state_next = ST_READ;
                        end
                        else if (!ovf_reg && wi_reg == WIW'(START_LEN))
                        begin
                            sel_next   = 1'b1;
                            state_next = ST_READ;
                        end
                    end
                end
            end

            ST_READ:
            begin
                // The store read data is registered this cycle.
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                if (rd_data_reg != cmd_char(sel_reg, idx_reg))
                begin
                    cmd_next   = CMD_NONE;
                    state_next = ST_DONE;
                end
                else if (idx_reg == last_idx)
                begin
                    cmd_next   = sel_reg ? CMD_START_RUN : CMD_STOP_RUN;
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 3'd1;
                    state_next = ST_READ;
                end
            end

            ST_DONE:
            begin
                // Hand the answer over once the output register is free.
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        out_cmd_next   = out_cmd_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_cmd_next   = cmd_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_reg       <= 2'd0;
            remain_reg    <= 8'd0;
            wi_reg        <= '0;
            ovf_reg       <= 1'b0;
            frame_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_reg       <= run_next;
            remain_reg    <= remain_next;
            wi_reg        <= wi_next;
            ovf_reg       <= ovf_next;
            frame_reg     <= frame_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers of the compare sequencer and output.
    always_ff @(posedge clk)
    begin
        sel_reg     <= sel_next;
        idx_reg     <= idx_next;
        cmd_reg     <= cmd_next;
        out_cmd_reg <= out_cmd_next;
    end

    // Payload store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[wi_reg[AW-1:0]] <= req.rx_byte;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

endmodule

// ----- hw/rtl/fcr_checker.sv -----
// ============================================================================
// Framed command receiver checker
// Port-level properties of the receiver, bound to the receiver core.
// ============================================================================
module fcr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       req_mode,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [1:0] rsp_command
);
    import fcr_pkg::*;

    // A stalled response keeps its answer.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_command))
        else $error("response changed while stalled");

    // Only defined answers are ever presented.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_command == CMD_NONE || rsp_command == CMD_STOP_RUN
                       || rsp_command == CMD_START_RUN))
        else $error("undefined command code");

    // A poll occupies the block for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_mode |=> !req_ready)
        else $error("request taken right after a poll");

    // No response is shown while in reset.
    assert property (@(posedge clk)
        !rst_n |-> !rsp_valid)
        else $error("response valid during reset");

endmodule

bind framed_command_receiver_core fcr_checker u_fcr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_mode    (req.mode),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_command (rsp.command)
);
